FILE: src/onb_pkg.sv
// Shared types and constants for the Oren-Nayar reflectance pipeline.
// No dependencies; every other file imports this package.
package onb_pkg;

   typedef struct packed {
      logic signed [15:0] light_x;
      logic signed [15:0] light_y;
      logic signed [15:0] light_z;
      logic signed [15:0] eye_x;
      logic signed [15:0] eye_y;
      logic signed [15:0] eye_z;
      logic        [15:0] roughness;
      logic signed [15:0] albedo_red;
      logic signed [15:0] albedo_green;
      logic signed [15:0] albedo_blue;
      logic               from_light;
   } req_type;

   typedef struct packed {
      logic [15:0] refl_red;
      logic [15:0] refl_green;
      logic [15:0] refl_blue;
      logic [15:0] direct_pdf;
      logic [15:0] reverse_pdf;
   } rsp_type;

   // A/B divider: remainder width and quotient bits
   localparam int AB_DEN_W = 37;
   localparam int AB_Q_W   = 27;
   // azimuth divider: dividend and divisor widths
   localparam int AZ_NUM_W = 58;
   localparam int AZ_DEN_W = 16;
   // bracket term width and per-channel output latency
   localparam int BRK_W    = 46;
   localparam int CHAN_LAT = 4;

   localparam logic [32:0] K_C033_Q24  = 33'd5536481;
   localparam logic [32:0] K_C009_Q24  = 33'd1509949;
   localparam logic [28:0] K_ONE_Q28   = 29'h1000_0000;
   localparam logic [31:0] K_INVPI_Q32 = 32'd1367130551;
   // z*z at most 2^30 - 11 keeps sin(theta) above 1e-4
   localparam logic [30:0] K_ZZ_MAX    = 31'd1073741813;
   localparam logic [12:0] K_ALB_ONE   = 13'd4096;

endpackage

FILE: src/onb_div_ab.sv
// Pipelined restoring divider for the A and B roughness terms, one quotient bit per stage.
// The dividend's low AB_Q_W bits are zero; num_hi is the part above them. Uses onb_pkg.
module onb_div_ab import onb_pkg::*; (
   input  logic                clock,
   input  logic [AB_DEN_W-1:0] num_hi,
   input  logic [AB_DEN_W-1:0] den,
   output logic [AB_Q_W-1:0]   quo
);

   logic [AB_DEN_W-1:0] rem_ff [AB_Q_W];
   logic [AB_DEN_W-1:0] den_ff [AB_Q_W];
   logic [AB_Q_W-1:0]   quo_ff [AB_Q_W];
   logic [AB_DEN_W-1:0] rem_in [AB_Q_W];
   logic [AB_DEN_W-1:0] den_in [AB_Q_W];
   logic [AB_Q_W-1:0]   quo_in [AB_Q_W];
   logic [AB_DEN_W:0]   trial  [AB_Q_W];
   logic [AB_DEN_W:0]   diff   [AB_Q_W];
   logic [AB_Q_W-1:0]   qout_in;
   logic [AB_Q_W-1:0]   qout_ff;

   always_comb begin
      rem_in[0] = num_hi;
      den_in[0] = den;
      quo_in[0] = '0;
      qout_in   = '0;
      for (int k = 0; k < AB_Q_W; k++) begin
         trial[k] = {rem_ff[k], 1'b0};
         diff[k]  = trial[k] - {1'b0, den_ff[k]};
      end
      for (int k = 1; k < AB_Q_W; k++) begin
         den_in[k] = den_ff[k-1];
         if (trial[k-1] >= {1'b0, den_ff[k-1]}) begin
            rem_in[k] = diff[k-1][AB_DEN_W-1:0];
            quo_in[k] = {quo_ff[k-1][AB_Q_W-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[k-1][AB_DEN_W-1:0];
            quo_in[k] = {quo_ff[k-1][AB_Q_W-2:0], 1'b0};
         end
      end
      qout_in = {quo_ff[AB_Q_W-1][AB_Q_W-2:0],
                 trial[AB_Q_W-1] >= {1'b0, den_ff[AB_Q_W-1]}};
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < AB_Q_W; k++) begin
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= den_in[k];
         quo_ff[k] <= quo_in[k];
      end
      qout_ff <= qout_in;
   end

   assign quo = qout_ff;

endmodule

FILE: src/onb_div_az.sv
// Pipelined restoring divider for the azimuth term: 58-bit dividend by a 16-bit divisor.
// One quotient bit per stage; a zero divisor gives a value the caller discards. Uses onb_pkg.
module onb_div_az import onb_pkg::*; (
   input  logic                clock,
   input  logic [AZ_NUM_W-1:0] num,
   input  logic [AZ_DEN_W-1:0] den,
   output logic [AZ_NUM_W-1:0] quo
);

   logic [AZ_DEN_W-1:0] rem_ff [AZ_NUM_W];
   logic [AZ_DEN_W-1:0] den_ff [AZ_NUM_W];
   logic [AZ_NUM_W-1:0] acc_ff [AZ_NUM_W];
   logic [AZ_DEN_W-1:0] rem_in [AZ_NUM_W];
   logic [AZ_DEN_W-1:0] den_in [AZ_NUM_W];
   logic [AZ_NUM_W-1:0] acc_in [AZ_NUM_W];
   logic [AZ_DEN_W:0]   trial  [AZ_NUM_W];
   logic [AZ_DEN_W:0]   diff   [AZ_NUM_W];
   logic [AZ_NUM_W-1:0] qout_in;
   logic [AZ_NUM_W-1:0] qout_ff;

   always_comb begin
      rem_in[0] = '0;
      den_in[0] = den;
      acc_in[0] = num;
      for (int k = 0; k < AZ_NUM_W; k++) begin
         trial[k] = {rem_ff[k], acc_ff[k][AZ_NUM_W-1]};
         diff[k]  = trial[k] - {1'b0, den_ff[k]};
      end
      for (int k = 1; k < AZ_NUM_W; k++) begin
         den_in[k] = den_ff[k-1];
         if (trial[k-1] >= {1'b0, den_ff[k-1]}) begin
            rem_in[k] = diff[k-1][AZ_DEN_W-1:0];
            acc_in[k] = {acc_ff[k-1][AZ_NUM_W-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[k-1][AZ_DEN_W-1:0];
            acc_in[k] = {acc_ff[k-1][AZ_NUM_W-2:0], 1'b0};
         end
      end
      qout_in = {acc_ff[AZ_NUM_W-1][AZ_NUM_W-2:0],
                 trial[AZ_NUM_W-1] >= {1'b0, den_ff[AZ_NUM_W-1]}};
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < AZ_NUM_W; k++) begin
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= den_in[k];
         acc_ff[k] <= acc_in[k];
      end
      qout_ff <= qout_in;
   end

   assign quo = qout_ff;

endmodule

FILE: src/onb_chan.sv
// One colour channel: bracket times albedo, then times 1/pi, in four register stages.
// The 1/pi product keeps only its low 64 bits, as a 64-bit datapath would. Uses onb_pkg.
module onb_chan import onb_pkg::*; (
   input  logic             clock,
   input  logic [BRK_W-1:0] bracket,
   input  logic [12:0]      alb,
   output logic [11:0]      refl
);

   logic [35:0] ph_ff, pl_ff;
   logic [35:0] x_ff;
   logic [49:0] pp0_ff, pp1_ff;
   logic [63:0] sum;
   logic [11:0] y_ff;

   assign sum = 64'(pp0_ff) + {pp1_ff[45:0], 18'b0};

   always_ff @(posedge clock) begin
      // split bracket in halves; the low half only feeds bits above the shift
      ph_ff  <= bracket[45:23] * alb;
      pl_ff  <= bracket[22:0] * alb;
      x_ff   <= ph_ff + 36'(pl_ff[35:23]);
      pp0_ff <= x_ff[17:0] * K_INVPI_Q32;
      pp1_ff <= x_ff[35:18] * K_INVPI_Q32;
      y_ff   <= sum[63:52];
   end

   assign refl = y_ff;

endmodule

FILE: src/oren_nayar_brdf_eval_core.sv
// Top level of the Oren-Nayar diffuse reflectance pipeline.
// Depends on onb_pkg, onb_div_ab, onb_div_az and onb_chan.
//
//   channel   ports                      direction  word
//   request   start, busy, req           in         req_type, taken on start & !busy
//   response  rsp_strobe, rsp            out        rsp_type, valid for one cycle
//
// One word is accepted every cycle; busy is always low. Each result follows its request
// through the 27-stage A/B divider and the 58-stage azimuth divider in series. Reset
// clears only the valid bits of the pipeline. The receiver cannot stall, so the pipeline
// advances on every clock.
module oren_nayar_brdf_eval_core import onb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_strobe,
   output rsp_type rsp
);

   typedef struct packed {
      logic        valid;
      logic [15:0] alz;
      logic [15:0] m;
      logic [31:0] maxd;
      logic [12:0] alb_r;
      logic [12:0] alb_g;
      logic [12:0] alb_b;
      logic [15:0] pdf_d;
      logic [15:0] pdf_r;
   } sb1_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] alz;
      logic        use_az;
      logic [44:0] brka;
      logic [12:0] alb_r;
      logic [12:0] alb_g;
      logic [12:0] alb_b;
      logic [15:0] pdf_d;
      logic [15:0] pdf_r;
   } sb2_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] pdf_d;
      logic [15:0] pdf_r;
   } tail_type;

   function automatic logic [12:0] clamp_alb(input logic [15:0] a);
      logic [12:0] r;
      if (a[15])
         r = '0;
      else if (a > 16'(K_ALB_ONE))
         r = K_ALB_ONE;
      else
         r = a[12:0];
      return r;
   endfunction

   function automatic logic [15:0] abs16(input logic [15:0] v);
      return v[15] ? 16'(~v + 16'd1) : v;
   endfunction

   // input register
   logic    v0_ff, v0_in;
   req_type in_ff;

   // stage 1: squares, products, magnitudes, clamped albedos
   logic               v1_ff;
   logic [31:0]        s2_ff;
   logic [30:0]        lzz_ff, ezz_ff;
   logic signed [31:0] pxx_ff, pyy_ff;
   logic [15:0]        alz_ff, aez_ff;
   logic [12:0]        albr_ff, albg_ff, albb_ff;
   logic               fl_ff;
   logic signed [31:0] lzz_full, ezz_full;

   // into the A/B dividers
   logic [AB_DEN_W-1:0] num_a, den_a, num_b, den_b;
   logic [33:0]         sb_c009;
   logic [AB_Q_W-1:0]   qa, qb;
   logic signed [32:0]  dot;
   logic                sin_ok;
   logic [47:0]         pdl, pde;
   sb1_type             sb1_in;
   sb1_type             sb1_ff [AB_Q_W+1];

   // after the A/B dividers
   logic [28:0]         aq;
   logic [58:0]         t_full;
   logic [44:0]         brka_full;
   logic [AZ_NUM_W-1:0] t_ff;
   logic [15:0]         m_ff;
   sb2_type             sbm_ff, sbm_in;
   sb2_type             sb2_ff [AZ_NUM_W+1];

   // after the azimuth divider
   logic [AZ_NUM_W-1:0] qz;
   logic [47:0]         rl_ff;
   logic [41:0]         rh_ff;
   sb2_type             r1_ff, r2_ff, r3_ff;
   logic [AZ_NUM_W-1:0] r_ff;
   logic [BRK_W-1:0]    bracket_ff;
   tail_type            tail_ff [CHAN_LAT];
   logic [11:0]         y_r, y_g, y_b;

   assign busy  = 1'b0;
   assign v0_in = start && !busy;

   assign lzz_full = in_ff.light_z * in_ff.light_z;
   assign ezz_full = in_ff.eye_z * in_ff.eye_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v0_ff;
      end
      in_ff   <= req;
      s2_ff   <= in_ff.roughness * in_ff.roughness;
      lzz_ff  <= lzz_full[30:0];
      ezz_ff  <= ezz_full[30:0];
      pxx_ff  <= in_ff.light_x * in_ff.eye_x;
      pyy_ff  <= in_ff.light_y * in_ff.eye_y;
      alz_ff  <= abs16(in_ff.light_z);
      aez_ff  <= abs16(in_ff.eye_z);
      albr_ff <= clamp_alb(in_ff.albedo_red);
      albg_ff <= clamp_alb(in_ff.albedo_green);
      albb_ff <= clamp_alb(in_ff.albedo_blue);
      fl_ff   <= in_ff.from_light;
   end

   // A = 1 - s2*2^27/(s2+0.33); B = 18*s2*2^27/(20*(s2+0.09))
   always_comb begin
      num_a   = AB_DEN_W'(s2_ff);
      den_a   = AB_DEN_W'(s2_ff) + AB_DEN_W'(K_C033_Q24);
      num_b   = AB_DEN_W'({s2_ff, 4'b0}) + AB_DEN_W'({s2_ff, 1'b0});
      sb_c009 = 34'(s2_ff) + 34'(K_C009_Q24);
      den_b   = AB_DEN_W'({sb_c009, 2'b0}) + AB_DEN_W'({sb_c009, 4'b0});
      sin_ok  = (lzz_ff <= K_ZZ_MAX) && (ezz_ff <= K_ZZ_MAX);
      dot     = 33'(pxx_ff) + 33'(pyy_ff);
      pdl     = alz_ff * K_INVPI_Q32;
      pde     = aez_ff * K_INVPI_Q32;
      sb1_in.valid = v1_ff;
      sb1_in.alz   = alz_ff;
      sb1_in.m     = (alz_ff > aez_ff) ? alz_ff : aez_ff;
      sb1_in.maxd  = (sin_ok && dot > 33'sd0) ? dot[31:0] : 32'd0;
      sb1_in.alb_r = albr_ff;
      sb1_in.alb_g = albg_ff;
      sb1_in.alb_b = albb_ff;
      sb1_in.pdf_d = fl_ff ? pde[46:31] : pdl[46:31];
      sb1_in.pdf_r = fl_ff ? pdl[46:31] : pde[46:31];
   end

   onb_div_ab u_div_a (
      .clock  (clock),
      .num_hi (num_a),
      .den    (den_a),
      .quo    (qa)
   );

   onb_div_ab u_div_b (
      .clock  (clock),
      .num_hi (num_b),
      .den    (den_b),
      .quo    (qb)
   );

   // carry the side data alongside the A/B dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= AB_Q_W; k++) sb1_ff[k].valid <= 1'b0;
      end else begin
         sb1_ff[0] <= sb1_in;
         for (int k = 1; k <= AB_Q_W; k++) sb1_ff[k] <= sb1_ff[k-1];
      end
   end

   always_comb begin
      aq        = K_ONE_Q28 - 29'(qa);
      t_full    = qb * sb1_ff[AB_Q_W].maxd;
      brka_full = sb1_ff[AB_Q_W].alz * aq;
      sbm_in.valid  = sb1_ff[AB_Q_W].valid;
      sbm_in.alz    = sb1_ff[AB_Q_W].alz;
      sbm_in.use_az = (sb1_ff[AB_Q_W].m != 16'd0) && (sb1_ff[AB_Q_W].maxd != 32'd0);
      sbm_in.brka   = brka_full;
      sbm_in.alb_r  = sb1_ff[AB_Q_W].alb_r;
      sbm_in.alb_g  = sb1_ff[AB_Q_W].alb_g;
      sbm_in.alb_b  = sb1_ff[AB_Q_W].alb_b;
      sbm_in.pdf_d  = sb1_ff[AB_Q_W].pdf_d;
      sbm_in.pdf_r  = sb1_ff[AB_Q_W].pdf_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sbm_ff.valid <= 1'b0;
      end else begin
         sbm_ff <= sbm_in;
      end
      t_ff <= t_full[AZ_NUM_W-1:0];
      m_ff <= sb1_ff[AB_Q_W].m;
   end

   onb_div_az u_div_z (
      .clock (clock),
      .num   (t_ff),
      .den   (m_ff),
      .quo   (qz)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= AZ_NUM_W; k++) sb2_ff[k].valid <= 1'b0;
         r1_ff.valid <= 1'b0;
         r2_ff.valid <= 1'b0;
         r3_ff.valid <= 1'b0;
         for (int k = 0; k < CHAN_LAT; k++) tail_ff[k].valid <= 1'b0;
      end else begin
         sb2_ff[0] <= sbm_ff;
         for (int k = 1; k <= AZ_NUM_W; k++) sb2_ff[k] <= sb2_ff[k-1];
         r1_ff <= sb2_ff[AZ_NUM_W];
         r2_ff <= r1_ff;
         r3_ff <= r2_ff;
         tail_ff[0].valid <= r3_ff.valid;
         tail_ff[0].pdf_d <= r3_ff.pdf_d;
         tail_ff[0].pdf_r <= r3_ff.pdf_r;
         for (int k = 1; k < CHAN_LAT; k++) tail_ff[k] <= tail_ff[k-1];
      end
      // quotient times |lz|, kept to the low 58 bits
      rl_ff      <= qz[31:0] * sb2_ff[AZ_NUM_W].alz;
      rh_ff      <= qz[57:32] * sb2_ff[AZ_NUM_W].alz;
      r_ff       <= AZ_NUM_W'(rl_ff) + {rh_ff[25:0], 32'b0};
      bracket_ff <= BRK_W'(r2_ff.brka)
                  + (r2_ff.use_az ? BRK_W'(r_ff[AZ_NUM_W-1:15]) : BRK_W'(0));
   end

   onb_chan u_chan_r (.clock(clock), .bracket(bracket_ff), .alb(r3_ff.alb_r), .refl(y_r));
   onb_chan u_chan_g (.clock(clock), .bracket(bracket_ff), .alb(r3_ff.alb_g), .refl(y_g));
   onb_chan u_chan_b (.clock(clock), .bracket(bracket_ff), .alb(r3_ff.alb_b), .refl(y_b));

   assign rsp_strobe      = tail_ff[CHAN_LAT-1].valid;
   assign rsp.refl_red    = {4'b0, y_r};
   assign rsp.refl_green  = {4'b0, y_g};
   assign rsp.refl_blue   = {4'b0, y_b};
   assign rsp.direct_pdf  = tail_ff[CHAN_LAT-1].pdf_d;
   assign rsp.reverse_pdf = tail_ff[CHAN_LAT-1].pdf_r;

endmodule
